// ===== rtl/core/rxs_pkg.sv =====
package rxs_pkg;

   // Fixed field widths
   localparam int SYM_W  = 4;
   localparam int DATA_W = 32;

   // Result kinds
   localparam logic KIND_POS = 1'b0;
   localparam logic KIND_SUM = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic load_item;
      logic upd_run;
      logic lower_run;
      logic raise;
      logic lower_lcp;
      logic commit_prev;
      logic flush_unsaved;
      logic emit_pos;
      logic emit_sum;
      logic finish;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic have_prev;
      logic same_sym;
      logic in_run;
      logic last;
      logic pending_any;
      logic hold_vld;
      logic out_free;
   } sts_type;

   // Commands into the candidate table
   typedef struct packed {
      logic lower;
      logic raise;
      logic flush;
      logic drain;
      logic clear;
   } cand_cmd_type;

endpackage

// ===== rtl/core/rxs_cand.sv =====
module rxs_cand
   import rxs_pkg::*;
#(
   parameter int ALPHABET_SIZE = 16,
   parameter int PSW           = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  cand_cmd_type      cmd,
   input  logic [DATA_W-1:0] level_lower,
   input  logic [DATA_W-1:0] level_raise,
   input  logic [SYM_W-1:0]  sym_a,
   input  logic [PSW-1:0]    pos_a,
   input  logic [SYM_W-1:0]  sym_b,
   input  logic [PSW-1:0]    pos_b,
   output logic              pending_any,
   output logic [PSW-1:0]    drain_pos
);

   // Per-symbol candidate: has (level valid, else "minus one"), level, position, saved
   logic [ALPHABET_SIZE-1:0] has_ff, has_in;
   logic [ALPHABET_SIZE-1:0] saved_ff, saved_in;
   logic [ALPHABET_SIZE-1:0] pend_ff, pend_in;
   logic [DATA_W-1:0]        level_ff [ALPHABET_SIZE];
   logic [DATA_W-1:0]        level_in [ALPHABET_SIZE];
   logic [PSW-1:0]           pos_ff [ALPHABET_SIZE];
   logic [PSW-1:0]           pos_in [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] onehot;

   // Lowest pending entry goes out first
   assign onehot      = pend_ff & (~pend_ff + ALPHABET_SIZE'(1));
   assign pending_any = |pend_ff;

   always_comb begin
      drain_pos = '0;
      for (int c = 0; c < ALPHABET_SIZE; c++) begin
         if (onehot[c]) begin
            drain_pos = drain_pos | pos_ff[c];
         end
      end
   end

   // Next state of the table; entry 0 (terminator) never becomes active
   always_comb begin
      logic hit_a;
      logic hit_b;
      hit_a    = 1'b0;
      hit_b    = 1'b0;
      has_in   = has_ff;
      saved_in = saved_ff;
      pend_in  = pend_ff;
      level_in = level_ff;
      pos_in   = pos_ff;
      if (cmd.clear) begin
         has_in   = '0;
         saved_in = '1;
         pend_in  = '0;
      end else begin
         if (cmd.drain) begin
            pend_in = pend_ff & ~onehot;
         end
         if (cmd.flush) begin
            pend_in = ~saved_ff;
         end
         for (int c = 0; c < ALPHABET_SIZE; c++) begin
            hit_a = (DATA_W'(sym_a) == DATA_W'(c)) && (c != 0);
            hit_b = (DATA_W'(sym_b) == DATA_W'(c)) && (c != 0);
            // lower everything above the level, mark unsaved ones for output
            if (cmd.lower && has_ff[c] && (level_ff[c] > level_lower)) begin
               pend_in[c]  = ~saved_ff[c];
               level_in[c] = level_lower;
               saved_in[c] = 1'b1;
            end
            // raise the two border symbols
            if (cmd.raise && (hit_a || hit_b) &&
                (!has_ff[c] || (level_raise > level_ff[c]))) begin
               has_in[c]   = 1'b1;
               level_in[c] = level_raise;
               pos_in[c]   = hit_a ? pos_a : pos_b;
               saved_in[c] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_ff   <= '0;
         saved_ff <= '1;
         pend_ff  <= '0;
      end else begin
         has_ff   <= has_in;
         saved_ff <= saved_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      pos_ff   <= pos_in;
   end

endmodule

// ===== rtl/core/rxs_dpath.sv =====
module rxs_dpath
   import rxs_pkg::*;
#(
   parameter int ALPHABET_SIZE = 16,
   parameter int POS_WIDTH     = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [DATA_W-1:0] csr_write_data,
   input  logic [SYM_W-1:0]  req_bwt_symbol,
   input  logic [DATA_W-1:0] req_lcp_value,
   input  logic [DATA_W-1:0] req_suffix_start,
   input  logic              req_last,
   input  cmd_type           cmd,
   output sts_type           sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_kind,
   output logic [DATA_W-1:0] rsp_position,
   output logic [DATA_W-1:0] rsp_border_count,
   output logic [DATA_W-1:0] rsp_set_size,
   output logic              rsp_end_of_run
);

   // Stored position width: only the low 32 bits ever leave the block
   localparam int PSW = (POS_WIDTH < DATA_W) ? POS_WIDTH : DATA_W;

   logic [DATA_W-1:0] text_len_ff;
   logic [SYM_W-1:0]  sym_ff, prev_sym_ff;
   logic [DATA_W-1:0] lcp_ff;
   logic [DATA_W-1:0] start_ff, prev_start_ff;
   logic              last_ff;
   logic              have_prev_ff, in_run_ff;
   logic [DATA_W-1:0] run_min_ff, borders_ff, emitted_ff;
   logic [DATA_W-1:0] rev_cur, rev_prev;

   logic              hold_vld_ff;
   logic              hold_kind_ff;
   logic [DATA_W-1:0] hold_pos_ff, hold_bord_ff, hold_size_ff;

   logic              rsp_valid_ff, rsp_kind_ff, rsp_end_ff;
   logic [DATA_W-1:0] rsp_pos_ff, rsp_bord_ff, rsp_size_ff;

   logic              out_free;
   logic              load_out;
   logic              produce;
   logic              pending_any;
   logic [PSW-1:0]    drain_pos;
   cand_cmd_type      ccmd;

   // Reversed positions N - start - 1, taken with the text length at raise time
   assign rev_cur  = text_len_ff + ~start_ff;
   assign rev_prev = text_len_ff + ~prev_start_ff;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         text_len_ff <= DATA_W'(2);
      end else if (csr_write_enable) begin
         text_len_ff <= csr_write_data;
      end
   end

   // Current row
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         sym_ff   <= req_bwt_symbol;
         lcp_ff   <= req_lcp_value;
         start_ff <= req_suffix_start;
         last_ff  <= req_last;
      end
   end

   // Scan state
   always_ff @(posedge clock) begin
      if (reset || cmd.emit_sum) begin
         prev_sym_ff   <= '0;
         prev_start_ff <= '0;
         have_prev_ff  <= 1'b0;
         run_min_ff    <= '0;
         in_run_ff     <= 1'b0;
         borders_ff    <= '0;
         emitted_ff    <= '0;
      end else begin
         if (cmd.upd_run) begin
            if (!in_run_ff || (lcp_ff < run_min_ff)) begin
               run_min_ff <= lcp_ff;
            end
            in_run_ff <= 1'b1;
         end
         if (cmd.lower_run) begin
            in_run_ff <= 1'b0;
         end
         if (cmd.raise) begin
            borders_ff <= borders_ff + DATA_W'(1);
         end
         if (cmd.commit_prev) begin
            prev_sym_ff   <= sym_ff;
            prev_start_ff <= start_ff;
            have_prev_ff  <= 1'b1;
         end
         if (cmd.emit_pos) begin
            emitted_ff <= emitted_ff + DATA_W'(1);
         end
      end
   end

   // Candidate table
   always_comb begin
      ccmd.lower = cmd.lower_run | cmd.lower_lcp;
      ccmd.raise = cmd.raise;
      ccmd.flush = cmd.flush_unsaved;
      ccmd.drain = cmd.emit_pos;
      ccmd.clear = cmd.emit_sum;
   end

   rxs_cand #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .PSW           (PSW)
   ) u_cand (
      .clock       (clock),
      .reset       (reset),
      .cmd         (ccmd),
      .level_lower (cmd.lower_run ? run_min_ff : lcp_ff),
      .level_raise (lcp_ff),
      .sym_a       (prev_sym_ff),
      .pos_a       (rev_prev[PSW-1:0]),
      .sym_b       (sym_ff),
      .pos_b       (rev_cur[PSW-1:0]),
      .pending_any (pending_any),
      .drain_pos   (drain_pos)
   );

   // Hold stage: one result waits here until we know whether it ends the item
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign produce  = cmd.emit_pos || cmd.emit_sum;
   assign load_out = (produce && hold_vld_ff) || cmd.finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else if (produce) begin
         hold_vld_ff <= 1'b1;
      end else if (cmd.finish) begin
         hold_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_pos) begin
         hold_kind_ff <= KIND_POS;
         hold_pos_ff  <= DATA_W'(drain_pos);
         hold_bord_ff <= '0;
         hold_size_ff <= '0;
      end else if (cmd.emit_sum) begin
         hold_kind_ff <= KIND_SUM;
         hold_pos_ff  <= '0;
         hold_bord_ff <= borders_ff;
         hold_size_ff <= emitted_ff;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= load_out || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_kind_ff <= hold_kind_ff;
         rsp_pos_ff  <= hold_pos_ff;
         rsp_bord_ff <= hold_bord_ff;
         rsp_size_ff <= hold_size_ff;
         rsp_end_ff  <= cmd.finish;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_border_count = rsp_bord_ff;
   assign rsp_set_size     = rsp_size_ff;
   assign rsp_end_of_run   = rsp_end_ff;

   // Status
   always_comb begin
      sts.have_prev   = have_prev_ff;
      sts.same_sym    = have_prev_ff && (sym_ff == prev_sym_ff);
      sts.in_run      = in_run_ff;
      sts.last        = last_ff;
      sts.pending_any = pending_any;
      sts.hold_vld    = hold_vld_ff;
      sts.out_free    = out_free;
   end

endmodule

// ===== rtl/core/rxs_ctrl.sv =====
module rxs_ctrl
   import rxs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_EVAL  = 4'd1;
   localparam logic [3:0] ST_RAISE = 4'd2;
   localparam logic [3:0] ST_LOWL  = 4'd3;
   localparam logic [3:0] ST_DRAIN = 4'd4;
   localparam logic [3:0] ST_TAIL  = 4'd5;
   localparam logic [3:0] ST_LAST  = 4'd6;
   localparam logic [3:0] ST_FLUSH = 4'd7;
   localparam logic [3:0] ST_SUMM  = 4'd8;
   localparam logic [3:0] ST_FIN   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [3:0] ret_ff, ret_in;
   logic       hold_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign hold_free = !sts.hold_vld || sts.out_free;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EVAL;
            end
         end
         // first row: commit only; same symbol: run update and commit; else close any open run and go raise
         ST_EVAL: begin
            if (!sts.have_prev || sts.same_sym) begin
               cmd.upd_run     = sts.have_prev;
               cmd.commit_prev = 1'b1;
               state_in        = sts.last ? ST_LAST : ST_IDLE;
            end else if (sts.in_run) begin
               cmd.lower_run = 1'b1;
               ret_in        = ST_RAISE;
               state_in      = ST_DRAIN;
            end else begin
               state_in = ST_RAISE;
            end
         end
         ST_RAISE: begin
            cmd.raise = 1'b1;
            state_in  = ST_LOWL;
         end
         ST_LOWL: begin
            cmd.lower_lcp = 1'b1;
            ret_in        = ST_TAIL;
            state_in      = ST_DRAIN;
         end
         // one emitted position per beat while the hold stage is free
         ST_DRAIN: begin
            if (sts.pending_any) begin
               cmd.emit_pos = hold_free;
            end else begin
               state_in = ret_ff;
            end
         end
         ST_TAIL: begin
            cmd.commit_prev = 1'b1;
            if (sts.last) begin
               state_in = ST_LAST;
            end else if (sts.hold_vld) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LAST: begin
            if (sts.in_run) begin
               cmd.lower_run = 1'b1;
               ret_in        = ST_FLUSH;
               state_in      = ST_DRAIN;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            cmd.flush_unsaved = 1'b1;
            ret_in            = ST_SUMM;
            state_in          = ST_DRAIN;
         end
         ST_SUMM: begin
            if (hold_free) begin
               cmd.emit_sum = 1'b1;
               state_in     = ST_FIN;
            end
         end
         // release the held result marked as the item's last
         ST_FIN: begin
            if (!sts.hold_vld) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

// ===== rtl/core/right_extension_set_scan_top.sv =====
// One row at a time; the input stalls until it is done. A border row closes any open run,
// raises its two symbols, lowers by its LCP, drains the emitted positions, and releases
// the final beat when it emitted something and is not a last row. A last row also closes
// any open run, flushes unsaved candidates, drains them and emits the summary.
// One beat per cycle; a stalled output holds the drain until the output register frees.
// Reset is synchronous, active high: clears scan state and candidates, text_length = 2.
module right_extension_set_scan_top
   import rxs_pkg::*;
#(
   parameter int ALPHABET_SIZE = 16,
   parameter int POS_WIDTH     = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [DATA_W-1:0] csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [SYM_W-1:0]  req_bwt_symbol,
   input  logic [DATA_W-1:0] req_lcp_value,
   input  logic [DATA_W-1:0] req_suffix_start,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_kind,
   output logic [DATA_W-1:0] rsp_position,
   output logic [DATA_W-1:0] rsp_border_count,
   output logic [DATA_W-1:0] rsp_set_size,
   output logic              rsp_end_of_run
);

   cmd_type cmd;
   sts_type sts;

   rxs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rxs_dpath #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .POS_WIDTH     (POS_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bwt_symbol   (req_bwt_symbol),
      .req_lcp_value    (req_lcp_value),
      .req_suffix_start (req_suffix_start),
      .req_last         (req_last),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_position     (rsp_position),
      .rsp_border_count (rsp_border_count),
      .rsp_set_size     (rsp_set_size),
      .rsp_end_of_run   (rsp_end_of_run)
   );

endmodule

// ===== rtl/core/rxs_checker.sv =====
module rxs_checker
   import rxs_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_kind,
   input logic [DATA_W-1:0] rsp_position,
   input logic [DATA_W-1:0] rsp_border_count,
   input logic [DATA_W-1:0] rsp_set_size,
   input logic              rsp_end_of_run
);

   // One row in flight: the input closes right after a beat
   a_one_row: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted a second row while busy");

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_position) && $stable(rsp_end_of_run))
      else $error("result beat changed under stall");

   // The summary closes its row and carries no position
   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_SUM) |-> rsp_end_of_run && (rsp_position == '0))
      else $error("summary not last or has a position");

   // Position beats carry no counts
   a_pos_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_POS) |->
         (rsp_border_count == '0) && (rsp_set_size == '0))
      else $error("position beat carries counts");

endmodule

bind right_extension_set_scan_top rxs_checker u_rxs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_position     (rsp_position),
   .rsp_border_count (rsp_border_count),
   .rsp_set_size     (rsp_set_size),
   .rsp_end_of_run   (rsp_end_of_run)
);
